// ----- rtl/core/hcg_pkg.sv -----
`default_nettype none

package hcg_pkg;

    localparam int MAX_CLUSTER_HITS = 9;
    localparam int COORD_BITS       = 8;
    localparam int TIME_BITS        = 40;
    localparam int ENERGY_BITS      = 16;
    localparam int WINDOW_BITS      = 16;
    localparam int SUM_BITS         = 32;
    localparam int COUNT_BITS       = 4;
    localparam int GRADE_BITS       = 3;

    localparam logic [GRADE_BITS-1:0]  GRADE_OUTLIER = 3'd7;
    localparam logic [WINDOW_BITS-1:0] WINDOW_RESET  = 16'd5;
    localparam logic [COUNT_BITS-1:0]  COUNT_LIMIT   = 4'd10;
    localparam logic [COUNT_BITS-1:0]  SLOT_LIMIT    = 4'd9;

    typedef struct packed {
        logic [COORD_BITS-1:0]  hit_x;
        logic [COORD_BITS-1:0]  hit_y;
        logic [TIME_BITS-1:0]   hit_time;
        logic [ENERGY_BITS-1:0] hit_energy;
        logic                   batch_end;
    } hit_word_t;

    typedef struct packed {
        logic [GRADE_BITS-1:0] grade;
        logic [TIME_BITS-1:0]  first_time;
        logic [TIME_BITS-1:0]  final_time;
        logic [SUM_BITS-1:0]   energy_total;
        logic                  run_last;
    } result_word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_WALK,
        ST_LOAD,
        ST_START
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic join_hit;
        logic start_cluster;
        logic walk_start;
        logic walk_step;
        logic load_result;
        logic run_last;
        logic close;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic joins;
        logic open;
        logic flush;
        logic walk_done;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// ----- rtl/core/hcg_ctrl.sv -----
`default_nettype none

module hcg_ctrl (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 hit_valid,
    output logic                hit_ready,
    input  hcg_pkg::dp_status_t status,
    output hcg_pkg::dp_cmd_t    cmd
);

    hcg_pkg::state_t state_reg, state_next;
    logic start_after_reg, start_after_next;  // open a new cluster after this result
    logic last_reg, last_next;                // run_last of the pending result

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= hcg_pkg::ST_IDLE;
            start_after_reg <= 1'b0;
            last_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            start_after_reg <= start_after_next;
            last_reg        <= last_next;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        start_after_next = start_after_reg;
        last_next        = last_reg;
        cmd              = '0;
        hit_ready        = 1'b0;
        case (state_reg)
            hcg_pkg::ST_IDLE:
            begin
                hit_ready = 1'b1;
                if (hit_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = hcg_pkg::ST_DECIDE;
                end
            end
            hcg_pkg::ST_DECIDE:
            begin
                if (status.joins)
                begin
                    cmd.join_hit = 1'b1;
                    if (status.flush)
                    begin
                        cmd.walk_start   = 1'b1;
                        last_next        = 1'b1;
                        start_after_next = 1'b0;
                        state_next       = hcg_pkg::ST_WALK;
                    end
                    else
                    begin
                        state_next = hcg_pkg::ST_IDLE;
                    end
                end
                else if (status.open)
                begin
                    // grade the old cluster first
                    cmd.walk_start   = 1'b1;
                    last_next        = !status.flush;
                    start_after_next = 1'b1;
                    state_next       = hcg_pkg::ST_WALK;
                end
                else
                begin
                    state_next = hcg_pkg::ST_START;
                end
            end
            hcg_pkg::ST_WALK:
            begin
                if (status.walk_done)
                begin
                    state_next = hcg_pkg::ST_LOAD;
                end
                else
                begin
                    cmd.walk_step = 1'b1;
                end
            end
            hcg_pkg::ST_LOAD:
            begin
                if (status.out_free)
                begin
                    cmd.load_result = 1'b1;
                    cmd.run_last    = last_reg;
                    if (start_after_reg)
                    begin
                        state_next = hcg_pkg::ST_START;
                    end
                    else
                    begin
                        cmd.close  = 1'b1;
                        state_next = hcg_pkg::ST_IDLE;
                    end
                end
            end
            hcg_pkg::ST_START:
            begin
                cmd.start_cluster = 1'b1;
                if (status.flush)
                begin
                    cmd.walk_start   = 1'b1;
                    last_next        = 1'b1;
                    start_after_next = 1'b0;
                    state_next       = hcg_pkg::ST_WALK;
                end
                else
                begin
                    state_next = hcg_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hcg_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/core/hcg_datapath.sv -----
`default_nettype none

module hcg_datapath (
    input  wire                   clk,
    input  wire                   rst_n,
    input  hcg_pkg::dp_cmd_t      cmd,
    output hcg_pkg::dp_status_t   status,
    input  hcg_pkg::hit_word_t    hit_word,
    input  wire                   cfg_we,
    input  wire [15:0]            cfg_wdata,
    output logic                  result_valid,
    input  wire                   result_ready,
    output hcg_pkg::result_word_t result_word
);

    localparam int CB = hcg_pkg::COORD_BITS;
    localparam int TB = hcg_pkg::TIME_BITS;
    localparam int EB = hcg_pkg::ENERGY_BITS;
    localparam int SB = hcg_pkg::SUM_BITS;
    localparam int NB = hcg_pkg::COUNT_BITS;
    localparam int NH = hcg_pkg::MAX_CLUSTER_HITS;

    // 3x3 weight grid, row by dy, column by dx (index 0 is offset -1)
    function automatic logic [7:0] weight_of(input logic [1:0] dyi, input logic [1:0] dxi);
        logic [7:0] w;
        case ({dyi, dxi})
            4'b0000: w = 8'd32;
            4'b0001: w = 8'd64;
            4'b0010: w = 8'd128;
            4'b0100: w = 8'd8;
            4'b0101: w = 8'd0;
            4'b0110: w = 8'd16;
            4'b1000: w = 8'd1;
            4'b1001: w = 8'd2;
            4'b1010: w = 8'd4;
            default: w = 8'd0;
        endcase
        return w;
    endfunction

    function automatic logic [2:0] grade_of(input logic [7:0] s);
        logic [2:0] g;
        case (s)
            8'd0: g = 3'd0;
            8'd1, 8'd4, 8'd32, 8'd128, 8'd5, 8'd33, 8'd132, 8'd160,
            8'd36, 8'd129, 8'd37, 8'd133, 8'd161, 8'd164, 8'd165:
                g = 3'd1;
            8'd64, 8'd65, 8'd68, 8'd69, 8'd2, 8'd34, 8'd130, 8'd162:
                g = 3'd2;
            8'd8, 8'd12, 8'd136, 8'd140:
                g = 3'd3;
            8'd16, 8'd17, 8'd48, 8'd49:
                g = 3'd4;
            8'd3, 8'd6, 8'd9, 8'd20, 8'd40, 8'd96, 8'd144, 8'd192,
            8'd13, 8'd21, 8'd35, 8'd38, 8'd44, 8'd52, 8'd97, 8'd100,
            8'd131, 8'd134, 8'd137, 8'd145, 8'd168, 8'd176, 8'd193,
            8'd196, 8'd53, 8'd101, 8'd141, 8'd163, 8'd166, 8'd172,
            8'd177, 8'd197:
                g = 3'd5;
            8'd72, 8'd76, 8'd104, 8'd108, 8'd10, 8'd11, 8'd138, 8'd139,
            8'd18, 8'd22, 8'd50, 8'd54, 8'd80, 8'd81, 8'd208, 8'd209:
                g = 3'd6;
            default: g = hcg_pkg::GRADE_OUTLIER;
        endcase
        return g;
    endfunction

    logic [15:0]    window_reg;
    hcg_pkg::hit_word_t hit_reg;

    logic           open_reg;
    logic [TB-1:0]  start_reg;
    logic [TB-1:0]  last_reg;
    logic [SB-1:0]  esum_reg;
    logic [EB-1:0]  peak_e_reg;
    logic [CB-1:0]  peak_x_reg;
    logic [CB-1:0]  peak_y_reg;
    logic [NB-1:0]  count_reg;
    logic [CB-1:0]  coord_x_reg [NH];
    logic [CB-1:0]  coord_y_reg [NH];

    logic [NB-1:0]  idx_reg;
    logic [7:0]     wsum_reg;
    logic           bad_reg;

    logic                  rvalid_reg;
    hcg_pkg::result_word_t rword_reg;

    // join test: borrow of one subtract gives t < last
    logic [TB:0]    tdiff;
    logic           joins;
    logic [SB:0]    esum_wide;
    logic [SB-1:0]  esum_sat;
    logic           peak_wins;

    logic [CB:0]    dx;
    logic [CB:0]    dy;
    logic [1:0]     dxi;
    logic [1:0]     dyi;
    logic           near;
    logic           over;

    assign tdiff     = {1'b0, hit_reg.hit_time} - {1'b0, last_reg};
    assign joins     = open_reg && (tdiff[TB] ||
                       (tdiff[TB-1:0] < {{(TB-16){1'b0}}, window_reg}));
    assign esum_wide = {1'b0, esum_reg} + {{(SB+1-EB){1'b0}}, hit_reg.hit_energy};
    assign esum_sat  = esum_wide[SB] ? {SB{1'b1}} : esum_wide[SB-1:0];
    assign peak_wins = hit_reg.hit_energy > peak_e_reg;

    assign over = count_reg > hcg_pkg::SLOT_LIMIT;
    assign dx   = {1'b0, coord_x_reg[idx_reg]} - {1'b0, peak_x_reg};
    assign dy   = {1'b0, coord_y_reg[idx_reg]} - {1'b0, peak_y_reg};

    always_comb
    begin
        near = 1'b1;
        dxi  = 2'd1;
        dyi  = 2'd1;
        if (dx == '0)
            dxi = 2'd1;
        else if (dx == {{CB{1'b0}}, 1'b1})
            dxi = 2'd2;
        else if (dx == '1)
            dxi = 2'd0;
        else
            near = 1'b0;
        if (dy == '0)
            dyi = 2'd1;
        else if (dy == {{CB{1'b0}}, 1'b1})
            dyi = 2'd2;
        else if (dy == '1)
            dyi = 2'd0;
        else
            near = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= hcg_pkg::WINDOW_RESET;
            open_reg   <= 1'b0;
            count_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                window_reg <= cfg_wdata;
            if (cmd.start_cluster)
            begin
                open_reg  <= 1'b1;
                count_reg <= {{(NB-1){1'b0}}, 1'b1};
            end
            else if (cmd.join_hit && count_reg < hcg_pkg::COUNT_LIMIT)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.close)
                open_reg <= 1'b0;
            if (cmd.load_result)
                rvalid_reg <= 1'b1;
            else if (result_ready)
                rvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            hit_reg <= hit_word;
        if (cmd.start_cluster)
        begin
            start_reg      <= hit_reg.hit_time;
            last_reg       <= hit_reg.hit_time;
            esum_reg       <= {{(SB-EB){1'b0}}, hit_reg.hit_energy};
            peak_e_reg     <= hit_reg.hit_energy;
            peak_x_reg     <= hit_reg.hit_x;
            peak_y_reg     <= hit_reg.hit_y;
            coord_x_reg[0] <= hit_reg.hit_x;
            coord_y_reg[0] <= hit_reg.hit_y;
        end
        else if (cmd.join_hit)
        begin
            last_reg <= hit_reg.hit_time;
            esum_reg <= esum_sat;
            if (peak_wins)
                peak_e_reg <= hit_reg.hit_energy;
            if (count_reg < hcg_pkg::SLOT_LIMIT)
            begin
                coord_x_reg[count_reg] <= hit_reg.hit_x;
                coord_y_reg[count_reg] <= hit_reg.hit_y;
                if (peak_wins)
                begin
                    peak_x_reg <= hit_reg.hit_x;
                    peak_y_reg <= hit_reg.hit_y;
                end
            end
        end
        if (cmd.walk_start)
        begin
            idx_reg  <= '0;
            wsum_reg <= '0;
            bad_reg  <= 1'b0;
        end
        else if (cmd.walk_step)
        begin
            idx_reg  <= idx_reg + 1'b1;
            wsum_reg <= wsum_reg + weight_of(dyi, dxi);
            if (!near)
                bad_reg <= 1'b1;
        end
        if (cmd.load_result)
        begin
            rword_reg.grade        <= (over || bad_reg) ? hcg_pkg::GRADE_OUTLIER
                                                        : grade_of(wsum_reg);
            rword_reg.first_time   <= start_reg;
            rword_reg.final_time   <= last_reg;
            rword_reg.energy_total <= esum_reg;
            rword_reg.run_last     <= cmd.run_last;
        end
    end

    assign status.joins     = joins;
    assign status.open      = open_reg;
    assign status.flush     = hit_reg.batch_end;
    assign status.walk_done = over || bad_reg || (idx_reg == count_reg);
    assign status.out_free  = !rvalid_reg || result_ready;

    assign result_valid = rvalid_reg;
    assign result_word  = rword_reg;

endmodule

`default_nettype wire

// ----- rtl/core/hit_cluster_grader.sv -----
// hit_cluster_grader: groups time-sorted detector hits into clusters and
// grades each closed cluster by its 3x3 pattern around the peak hit.
// Hit channel: hit_valid/hit_ready carry one hit_word (x, y, time, energy,
// batch_end). Result channel: result_valid/result_ready carry one
// result_word (grade, first/final time, energy total, run_last).
// cfg_we/cfg_wdata write cluster_window; write only while idle.
// A hit that joins the open cluster without a flush passes through decide
// only; one that opens a cluster with nothing to close passes through
// decide and start. Grading a cluster of up to 9 stored hits walks the
// stored hits against the peak, one hit per cycle, then loads the result
// into the output register; the walk stops early once the cluster is known
// to be an outlier. A closing hit grades the old cluster, then starts its
// own; with a flush it then grades its own cluster as well.
// At most two result words per hit, the last one flagged by run_last.
// Reset clears the open flag, hit count, output valid and sets the window
// to 5. The result sits in an output register: the next hit may be taken
// while it waits, but a further result stalls the block until the
// receiver takes the pending word.
`default_nettype none

module hit_cluster_grader (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   hit_valid,
    output logic                  hit_ready,
    input  hcg_pkg::hit_word_t    hit_word,
    output logic                  result_valid,
    input  wire                   result_ready,
    output hcg_pkg::result_word_t result_word,
    input  wire                   cfg_we,
    input  wire [15:0]            cfg_wdata
);

    hcg_pkg::dp_cmd_t    cmd;
    hcg_pkg::dp_status_t status;

    // sequencer: decide, walk, load, start
    hcg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .hit_valid (hit_valid),
        .hit_ready (hit_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // cluster state, grading walk and output register
    hcg_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .hit_word     (hit_word),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_word  (result_word)
    );

endmodule

`default_nettype wire

// ----- tb/hit_cluster_grader_tb.sv -----
module hit_cluster_grader_tb;

    // Clock period is 4; the block is held in reset at the start, then it is never reset again.
    localparam int SETTLE_CYCLES = 40;   // room for the longest close-and-grade walk
    localparam int REPORT_LIMIT  = 10;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // Hit side: driven at the falling edge and held until the block takes the word.
    logic                  hit_valid = 1'b0;
    logic                  hit_ready;
    hcg_pkg::hit_word_t    hit_word = '0;

    // Result side.
    logic                  result_valid;
    logic                  result_ready = 1'b0;
    hcg_pkg::result_word_t result_word;

    logic         cfg_we = 1'b0;
    logic [15:0]  cfg_wdata = '0;

    hit_cluster_grader uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .hit_valid    (hit_valid),
        .hit_ready    (hit_ready),
        .hit_word     (hit_word),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_word  (result_word),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata)
    );

    initial
    begin
        forever
        begin
            #2 clk = ~clk;
        end
    end

    // ------------------------------------------------------------------
    // Cluster tracker: our own copy of the clustering state, advanced on
    // every hit word the block accepts.
    // ------------------------------------------------------------------
    logic [15:0]  join_window = hcg_pkg::WINDOW_RESET;
    logic         clu_open = 1'b0;
    logic [39:0]  clu_first = '0;
    logic [39:0]  clu_last = '0;
    logic [31:0]  clu_energy = '0;
    logic [15:0]  clu_peak_e = '0;
    int           clu_peak_slot = 0;
    int           clu_hits = 0;      // saturates at one past the store depth
    logic [7:0]   slot_x [hcg_pkg::MAX_CLUSTER_HITS];
    logic [7:0]   slot_y [hcg_pkg::MAX_CLUSTER_HITS];

    hcg_pkg::hit_word_t    pending_hits [$];  // words still to be offered
    hcg_pkg::result_word_t graded_q [$];      // graded clusters awaiting the block's result
    hcg_pkg::result_word_t oldest_word;

    int           fault_count = 0;
    int           queued_count = 0;
    logic [39:0]  stamp_now = '0;    // time of the last hit queued

    // Handshake bookkeeping shared between the edges.
    logic         word_taken = 1'b0;
    logic         result_taken = 1'b0;
    int           send_gap = 0;
    int           recv_gap = 0;
    logic         send_idle = 1'b1;
    logic         recv_idle = 1'b1;

    // 3x3 weights around the peak: top row is dy = -1.
    function automatic logic [7:0] pixel_weight(input int dx, input int dy);
        case ((dy + 1) * 3 + (dx + 1))
            0: return 8'd32;
            1: return 8'd64;
            2: return 8'd128;
            3: return 8'd8;
            4: return 8'd0;
            5: return 8'd16;
            6: return 8'd1;
            7: return 8'd2;
            default: return 8'd4;
        endcase
    endfunction

    // Pattern sum to grade; anything not listed is an outlier.
    function automatic logic [2:0] grade_from_sum(input logic [7:0] sum);
        case (sum)
            8'd0:
                return 3'd0;
            8'd1, 8'd4, 8'd32, 8'd128, 8'd5, 8'd33, 8'd132, 8'd160, 8'd36, 8'd129,
            8'd37, 8'd133, 8'd161, 8'd164, 8'd165:
                return 3'd1;
            8'd64, 8'd65, 8'd68, 8'd69, 8'd2, 8'd34, 8'd130, 8'd162:
                return 3'd2;
            8'd8, 8'd12, 8'd136, 8'd140:
                return 3'd3;
            8'd16, 8'd17, 8'd48, 8'd49:
                return 3'd4;
            8'd3, 8'd6, 8'd9, 8'd20, 8'd40, 8'd96, 8'd144, 8'd192, 8'd13, 8'd21,
            8'd35, 8'd38, 8'd44, 8'd52, 8'd97, 8'd100, 8'd131, 8'd134, 8'd137,
            8'd145, 8'd168, 8'd176, 8'd193, 8'd196, 8'd53, 8'd101, 8'd141,
            8'd163, 8'd166, 8'd172, 8'd177, 8'd197:
                return 3'd5;
            8'd72, 8'd76, 8'd104, 8'd108, 8'd10, 8'd11, 8'd138, 8'd139, 8'd18,
            8'd22, 8'd50, 8'd54, 8'd80, 8'd81, 8'd208, 8'd209:
                return 3'd6;
            default:
                return hcg_pkg::GRADE_OUTLIER;
        endcase
    endfunction

    // Grade of the open cluster. Too many hits, or a peak past the store, is an outlier
    // straight away; otherwise every stored hit must sit within one pixel of the peak.
    function automatic logic [2:0] cluster_grade();
        int         dx;
        int         dy;
        int         i;
        logic [7:0] sum;
        if (clu_hits > hcg_pkg::MAX_CLUSTER_HITS ||
            clu_peak_slot >= hcg_pkg::MAX_CLUSTER_HITS)
            return hcg_pkg::GRADE_OUTLIER;
        sum = '0;
        for (i = 0; i < clu_hits; i++)
        begin
            dx = int'(slot_x[i]) - int'(slot_x[clu_peak_slot]);
            dy = int'(slot_y[i]) - int'(slot_y[clu_peak_slot]);
            if (dx < -1 || dx > 1 || dy < -1 || dy > 1)
                return hcg_pkg::GRADE_OUTLIER;
            sum = sum + pixel_weight(dx, dy);   // wraps at 8 bits
        end
        return grade_from_sum(sum);
    endfunction

    function automatic hcg_pkg::result_word_t closed_cluster();
        hcg_pkg::result_word_t r;
        r.grade        = cluster_grade();
        r.first_time   = clu_first;
        r.final_time   = clu_last;
        r.energy_total = clu_energy;
        r.run_last     = 1'b0;
        return r;
    endfunction

    // Fold one accepted hit word into the tracker and queue what it closes.
    task automatic absorb_hit(input hcg_pkg::hit_word_t w);
        hcg_pkg::result_word_t closed [2];
        int           n;
        int           i;
        logic         joins;
        logic [32:0]  wide;
        n = 0;
        // Earlier than the last hit always joins; no wrap in the window test.
        joins = clu_open && (w.hit_time < clu_last ||
                             (w.hit_time - clu_last) < {24'd0, join_window});
        if (joins)
        begin
            clu_last   = w.hit_time;
            wide       = {1'b0, clu_energy} + {17'd0, w.hit_energy};
            clu_energy = wide[32] ? 32'hFFFF_FFFF : wide[31:0];
            if (clu_hits < hcg_pkg::MAX_CLUSTER_HITS)
            begin
                slot_x[clu_hits] = w.hit_x;
                slot_y[clu_hits] = w.hit_y;
                if (w.hit_energy > clu_peak_e)
                begin
                    clu_peak_e    = w.hit_energy;
                    clu_peak_slot = clu_hits;
                end
            end
            else if (w.hit_energy > clu_peak_e)
            begin
                // peak beyond the store: forces an outlier
                clu_peak_e    = w.hit_energy;
                clu_peak_slot = hcg_pkg::MAX_CLUSTER_HITS;
            end
            if (clu_hits < hcg_pkg::MAX_CLUSTER_HITS + 1)
                clu_hits++;
        end
        else
        begin
            if (clu_open)
            begin
                closed[n] = closed_cluster();
                n++;
            end
            clu_open      = 1'b1;
            clu_first     = w.hit_time;
            clu_last      = w.hit_time;
            clu_energy    = {16'd0, w.hit_energy};
            clu_peak_e    = w.hit_energy;
            clu_peak_slot = 0;
            clu_hits      = 1;
            slot_x[0]     = w.hit_x;
            slot_y[0]     = w.hit_y;
        end
        // Batch end flushes after the hit has been placed.
        if (w.batch_end)
        begin
            closed[n] = closed_cluster();
            n++;
            clu_open = 1'b0;
        end
        for (i = 0; i < n; i++)
        begin
            closed[i].run_last = (i == n - 1);
            graded_q.insert(graded_q.size(), closed[i]);
        end
    endtask

    task automatic flag_fault(input string why, input hcg_pkg::result_word_t want,
                              input hcg_pkg::result_word_t got);
        fault_count++;
        if (fault_count <= REPORT_LIMIT)
        begin
            $display("%0t %s: expected grade %0d first %h final %h energy %h last %b",
                     $realtime, why, want.grade, want.first_time, want.final_time,
                     want.energy_total, want.run_last);
            $display("%0t %s: got      grade %0d first %h final %h energy %h last %b",
                     $realtime, why, got.grade, got.first_time, got.final_time,
                     got.energy_total, got.run_last);
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: everything is sampled at the rising edge.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hit_valid && hit_ready)
            begin
                absorb_hit(hit_word);
                word_taken = 1'b1;
            end
            if (result_valid && result_ready)
            begin
                result_taken = 1'b1;
                if (graded_q.size() == 0)
                    flag_fault("result word with nothing expected", '0, result_word);
                else
                begin
                    oldest_word = graded_q.pop_front();
                    if (result_word.grade        != oldest_word.grade        ||
                        result_word.first_time   != oldest_word.first_time   ||
                        result_word.final_time   != oldest_word.final_time   ||
                        result_word.energy_total != oldest_word.energy_total ||
                        result_word.run_last     != oldest_word.run_last)
                        flag_fault("result word mismatch", oldest_word, result_word);
                end
            end
        end
    end

    function automatic int draw_gap(input logic idle_on);
        return idle_on ? $urandom_range(0, 7) : 0;
    endfunction

    // ------------------------------------------------------------------
    // Driver: both sides change at the falling edge. Each word draws its own
    // gap; the idle mode flips now and then so there are runs with no gaps.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (word_taken || !hit_valid)
            begin
                word_taken = 1'b0;
                if (send_gap > 0)
                begin
                    send_gap--;
                    hit_valid <= 1'b0;
                end
                else if (pending_hits.size() != 0)
                begin
                    hit_word  <= pending_hits.pop_front();
                    hit_valid <= 1'b1;
                    send_gap  = draw_gap(send_idle);
                    if ($urandom_range(0, 39) == 0)
                        send_idle = !send_idle;
                end
                else
                    hit_valid <= 1'b0;
            end

            if (result_taken)
            begin
                result_taken = 1'b0;
                recv_gap     = draw_gap(recv_idle);
                if ($urandom_range(0, 29) == 0)
                    recv_idle = !recv_idle;
            end
            if (recv_gap > 0)
            begin
                recv_gap--;
                result_ready <= 1'b0;
            end
            else
                result_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_hit(input logic [7:0] x, input logic [7:0] y, input logic [39:0] t,
                            input logic [15:0] e, input logic be);
        hcg_pkg::hit_word_t w;
        w.hit_x      = x;
        w.hit_y      = y;
        w.hit_time   = t;
        w.hit_energy = e;
        w.batch_end  = be;
        pending_hits.insert(pending_hits.size(), w);
        queued_count++;
    endtask

    function automatic logic [39:0] random_stamp();
        logic [39:0] r;
        r[31:0]  = $urandom;
        r[39:32] = $urandom_range(0, 255);
        return r;
    endfunction

    // Next hit inside a cluster: within the window, or now and then backwards
    // (with a zero window, backwards is the only way to join).
    function automatic logic [39:0] next_in_cluster(input logic [39:0] t);
        if (join_window == 0 || $urandom_range(0, 15) == 0)
            return t - $urandom_range(1, 9);
        return t + $urandom_range(0, join_window - 1);
    endfunction

    // One cluster around a random centre: the peak carries the top energy, the
    // rest sit in the 3x3 square, with the odd stray two pixels out and the odd
    // energy tie. Mostly small clusters, some past the store depth.
    task automatic queue_cluster();
        int          n_hits;
        int          peak_at;
        int          i;
        int          dx;
        int          dy;
        logic [7:0]  cx;
        logic [7:0]  cy;
        logic [15:0] top_e;
        logic [15:0] e;
        logic [39:0] t;
        logic        be;
        n_hits  = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(5, 12);
        cx      = $urandom_range(0, 255);
        cy      = $urandom_range(0, 255);
        top_e   = $urandom_range(1, 16'hFFFF);
        peak_at = $urandom_range(0, n_hits - 1);
        t       = stamp_now + join_window + $urandom_range(0, 3);
        for (i = 0; i < n_hits; i++)
        begin
            if (i > 0)
                t = next_in_cluster(t);
            if (i == peak_at)
            begin
                dx = 0;
                dy = 0;
                e  = top_e;
            end
            else
            begin
                dx = $urandom_range(0, 2) - 1;
                dy = $urandom_range(0, 2) - 1;
                if ($urandom_range(0, 19) == 0)
                    dx = $urandom_range(0, 1) ? 2 : -2;
                e = ($urandom_range(0, 7) == 0) ? top_e : $urandom_range(0, top_e - 1);
            end
            if (i == n_hits - 1)
                be = ($urandom_range(0, 3) == 0);
            else
                be = ($urandom_range(0, 39) == 0);
            push_hit(cx + dx, cy + dy, t, e, be);
        end
        stamp_now = t;
    endtask

    // Noise: a hit with every field random.
    task automatic queue_noise();
        logic [39:0] t;
        t = random_stamp();
        push_hit($urandom_range(0, 255), $urandom_range(0, 255), t,
                 $urandom_range(0, 16'hFFFF), $urandom_range(0, 1));
        stamp_now = t;
    endtask

    task automatic queue_random(input int n_words);
        int target;
        target = queued_count + n_words;
        while (queued_count < target)
        begin
            if ($urandom_range(0, 9) == 0)
                queue_noise();
            else
                queue_cluster();
        end
    endtask

    // Hold the sender until every graded cluster has come back, then give the
    // block time to finish a word that closes nothing.
    task automatic wait_quiet();
        while (pending_hits.size() != 0 || hit_valid || graded_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_window(input logic [15:0] w);
        @(negedge clk);
        cfg_we      <= 1'b1;
        cfg_wdata   <= w;
        join_window = w;
        @(negedge clk);
        cfg_we      <= 1'b0;
    endtask

    task automatic run_phase(input logic [15:0] w, input logic [39:0] base,
                             input int n_words);
        wait_quiet();
        set_window(w);
        stamp_now = base;
        queue_random(n_words);
    endtask

    // Short directed run on the reset window of 5.
    task automatic queue_directed();
        int i;
        // field extremes, each flushed on its own
        push_hit(8'd0, 8'd0, 40'd0, 16'd0, 1'b1);
        push_hit(8'd255, 8'd255, 40'hFF_FFFF_FFFF, 16'hFFFF, 1'b1);
        // peak with three neighbours, closed by the next cluster's first hit
        push_hit(8'd100, 8'd100, 40'd1000, 16'd500, 1'b0);
        push_hit(8'd99, 8'd99, 40'd1001, 16'd10, 1'b0);
        push_hit(8'd101, 8'd101, 40'd1002, 16'd10, 1'b0);
        push_hit(8'd100, 8'd99, 40'd1003, 16'd10, 1'b0);
        // new cluster; the second hit goes back in time yet still joins
        push_hit(8'd10, 8'd10, 40'd2000, 16'd50, 1'b0);
        push_hit(8'd11, 8'd10, 40'd1990, 16'd100, 1'b0);
        push_hit(8'd12, 8'd10, 40'd1995, 16'd5, 1'b1);
        // hit two pixels off the peak
        push_hit(8'd50, 8'd50, 40'd3000, 16'd300, 1'b0);
        push_hit(8'd52, 8'd50, 40'd3001, 16'd1, 1'b0);
        // out of window with batch end: two words from one hit
        push_hit(8'd60, 8'd60, 40'd9000, 16'd7, 1'b1);
        // one hit more than the store holds
        for (i = 0; i <= hcg_pkg::MAX_CLUSTER_HITS; i++)
            push_hit(8'd200, 8'd200, 40'd20000 + i, 16'd1, i == hcg_pkg::MAX_CLUSTER_HITS);
        stamp_now = 40'd20000 + hcg_pkg::MAX_CLUSTER_HITS;
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        queue_directed();

        // Window settings: zero, widest, narrowest non-zero, reset value, random.
        run_phase(16'd0, random_stamp(), 290);
        run_phase(16'hFFFF, random_stamp(), 290);
        run_phase(16'd1, 40'hFF_FFFF_FF00, 290);    // runs the clock over the top
        run_phase(16'd5, random_stamp(), 290);
        run_phase($urandom_range(2, 64), random_stamp(), 300);
        run_phase($urandom_range(0, 16'hFFFF), random_stamp(), 290);

        // A short random tail on a narrow window.
        run_phase(16'd3, random_stamp(), 40);
        wait_quiet();

        if (fault_count == 0 && graded_q.size() == 0)
            $display("hit_cluster_grader_tb passed");
        else
            $display("hit_cluster_grader_tb failed");
        $finish;
    end

    // Watchdog, well clear of the slowest legal run.
    initial
    begin
        #12000000;
        $display("hit_cluster_grader_tb failed");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/hcg_pkg.sv
rtl/core/hcg_ctrl.sv
rtl/core/hcg_datapath.sv
rtl/core/hit_cluster_grader.sv
tb/hit_cluster_grader_tb.sv
